// ===== rtl/bcpu_pkg.sv =====
// shared types, constants and codes for the block cipher pad and unpad engine
`default_nettype none
package bcpu_pkg;

	localparam int MAX_BLOCK   = 32;
	localparam int LENGTH_BITS = 16;
	localparam int BLK_W       = $clog2(MAX_BLOCK + 1);
	localparam int POS_W       = $clog2(MAX_BLOCK);
	localparam int LEN_W       = LENGTH_BITS;
	localparam int Q_DEPTH     = 2;
	localparam int Q_PTR_W     = $clog2(Q_DEPTH);
	localparam int Q_CNT_W     = $clog2(Q_DEPTH + 1);
	localparam int ADDR_W      = 4;
	localparam int DATA_W      = 32;

	localparam logic [LEN_W-1:0] LEN_MAX = {LEN_W{1'b1}};

	localparam logic [7:0] MARKER_BYTE = 8'h80;
	localparam logic [7:0] ZERO_BYTE   = 8'h00;
	localparam logic [5:0] RUN_MAX     = 6'd63;

	localparam logic CMD_DATA = 1'b0;
	localparam logic CMD_END  = 1'b1;

	localparam logic [1:0] MODE_ZERO   = 2'd0;
	localparam logic [1:0] MODE_MARKER = 2'd1;
	localparam logic [1:0] MODE_PKCS   = 2'd2;
	localparam logic [1:0] MODE_SPARE  = 2'd3;

	localparam logic DIR_PAD   = 1'b0;
	localparam logic DIR_UNPAD = 1'b1;

	localparam logic [1:0] KIND_DATA   = 2'd0;
	localparam logic [1:0] KIND_PAD    = 2'd1;
	localparam logic [1:0] KIND_STATUS = 2'd2;

	localparam logic [1:0] REG_SCHEME    = 2'd0;
	localparam logic [1:0] REG_DIRECTION = 2'd1;
	localparam logic [1:0] REG_BLOCK     = 2'd2;

	localparam logic [5:0] BLOCK_RESET = 6'd16;

	typedef struct packed {
		logic       cmd;
		logic [7:0] data_byte;
	} in_item_t;

	typedef struct packed {
		logic [7:0]       out_byte;
		logic [1:0]       out_kind;
		logic [LEN_W-1:0] total_length;
		logic             ok;
		logic             last;
	} out_item_t;

	typedef struct packed {
		logic [1:0] scheme_mode;
		logic       direction;
		logic [5:0] block_length;
	} cfg_t;

	typedef struct packed {
		logic             is_end;
		logic [7:0]       data_byte;
		logic [BLK_W-1:0] pads;
		logic [7:0]       first_byte;
		logic [7:0]       fill_byte;
		logic [LEN_W-1:0] total;
		logic             ok;
	} job_t;

endpackage
`default_nettype wire

// ===== rtl/bcpu_front.sv =====
// front end: accepts items, tracks message state and classifies each into a job
`default_nettype none
module bcpu_front (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire bcpu_pkg::cfg_t    cfg,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire bcpu_pkg::in_item_t in_item,
	input  wire logic              full,
	output logic                   push,
	output bcpu_pkg::job_t         push_job
);
	import bcpu_pkg::*;

	logic [LEN_W-1:0] count_q;
	logic [POS_W-1:0] pos_q;
	logic             ovf_q;
	logic [LEN_W-1:0] marker_q;
	logic             marker_valid_q;
	logic [7:0]       run_value_q;
	logic [5:0]       run_count_q;

	logic [BLK_W-1:0] blk;
	logic [BLK_W-1:0] pos_w;
	logic [BLK_W-1:0] pos_inc;
	logic             reducing;
	logic [1:0]       mode;
	logic [BLK_W-1:0] pads;
	logic [LEN_W:0]   pad_sum;
	logic             marker_fit;
	logic             pkcs_fit;
	logic [LEN_W-1:0] end_total;
	logic             end_ok;
	logic             accept;
	logic             is_end;

	always_comb begin
		if (cfg.block_length == '0) begin
			blk = BLK_W'(1);
		end else if (cfg.block_length > BLK_W'(MAX_BLOCK)) begin
			blk = BLK_W'(MAX_BLOCK);
		end else begin
			blk = cfg.block_length;
		end
	end

	assign pos_w    = BLK_W'(pos_q);
	assign pos_inc  = pos_w + BLK_W'(1);
	assign reducing = (pos_w >= blk);
	assign mode     = (cfg.scheme_mode == MODE_SPARE) ? MODE_ZERO : cfg.scheme_mode;
	assign in_ready = !reducing && !full;
	assign accept   = in_valid && in_ready;
	assign is_end   = (in_item.cmd == CMD_END);

	assign pads    = (mode == MODE_ZERO && pos_q == '0) ? '0 : (blk - pos_w);
	assign pad_sum = {1'b0, count_q} + (LEN_W+1)'(pads);

	assign marker_fit = ({1'b0, marker_q} + (LEN_W+1)'(blk)) >= {1'b0, count_q};
	assign pkcs_fit   = (run_value_q != ZERO_BYTE) && (run_value_q <= 8'(blk))
		&& (8'(run_count_q) >= run_value_q) && (count_q >= LEN_W'(run_value_q));

	always_comb begin
		end_total = '0;
		end_ok    = 1'b0;
		if (cfg.direction == DIR_PAD) begin
			if (pad_sum > (LEN_W+1)'(LEN_MAX)) begin
				end_total = LEN_MAX;
			end else begin
				end_total = pad_sum[LEN_W-1:0];
				end_ok    = !ovf_q;
			end
		end else if (!ovf_q && pos_q == '0) begin
			if (mode == MODE_ZERO) begin
				end_ok    = 1'b1;
				end_total = count_q;
			end else if (mode == MODE_MARKER) begin
				if (count_q != '0 && marker_valid_q && marker_fit) begin
					end_ok    = 1'b1;
					end_total = marker_q;
				end
			end else begin
				if (count_q != '0 && pkcs_fit) begin
					end_ok    = 1'b1;
					end_total = count_q - LEN_W'(run_value_q);
				end
			end
		end
	end

	always_comb begin
		push_job            = '0;
		push_job.is_end     = is_end;
		push_job.data_byte  = in_item.data_byte;
		push_job.total      = end_total;
		push_job.ok         = end_ok;
		if (cfg.direction == DIR_PAD) begin
			push_job.pads = pads;
			if (mode == MODE_MARKER) begin
				push_job.first_byte = MARKER_BYTE;
				push_job.fill_byte  = ZERO_BYTE;
			end else if (mode == MODE_PKCS) begin
				push_job.first_byte = 8'(pads);
				push_job.fill_byte  = 8'(pads);
			end else begin
				push_job.first_byte = ZERO_BYTE;
				push_job.fill_byte  = ZERO_BYTE;
			end
		end
	end

	assign push = accept;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q        <= '0;
			pos_q          <= '0;
			ovf_q          <= 1'b0;
			marker_q       <= '0;
			marker_valid_q <= 1'b0;
			run_value_q    <= '0;
			run_count_q    <= '0;
		end else if (reducing) begin
			// block length shrank mid message: bring position back into range
			pos_q <= POS_W'(pos_w - blk);
		end else if (accept) begin
			if (is_end) begin
				count_q        <= '0;
				pos_q          <= '0;
				ovf_q          <= 1'b0;
				marker_q       <= '0;
				marker_valid_q <= 1'b0;
				run_value_q    <= '0;
				run_count_q    <= '0;
			end else begin
				if (in_item.data_byte == MARKER_BYTE) begin
					marker_q       <= count_q;
					marker_valid_q <= 1'b1;
				end else if (in_item.data_byte != ZERO_BYTE) begin
					marker_valid_q <= 1'b0;
				end
				if (run_count_q != '0 && in_item.data_byte == run_value_q) begin
					if (run_count_q < RUN_MAX) begin
						run_count_q <= run_count_q + 6'd1;
					end
				end else begin
					run_value_q <= in_item.data_byte;
					run_count_q <= 6'd1;
				end
				if (count_q == LEN_MAX) begin
					ovf_q <= 1'b1;
				end else begin
					count_q <= count_q + LEN_W'(1);
				end
				pos_q <= (pos_inc == blk) ? '0 : POS_W'(pos_inc);
			end
		end
	end

	a_reduce_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		reducing |-> !in_ready)
		else $error("item taken while position out of range");

	a_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && is_end) |=> (count_q == '0 && pos_q == '0 && !ovf_q))
		else $error("message state not cleared after end");

endmodule
`default_nettype wire

// ===== rtl/bcpu_fifo.sv =====
// short job queue between front and back
`default_nettype none
module bcpu_fifo (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	input  wire bcpu_pkg::job_t push_job,
	output logic                full,
	output logic                not_empty,
	input  wire logic           pop,
	output bcpu_pkg::job_t      head
);
	import bcpu_pkg::*;

	job_t               mem_q [Q_DEPTH];
	logic [Q_PTR_W-1:0] wr_ptr_q;
	logic [Q_PTR_W-1:0] rd_ptr_q;
	logic [Q_CNT_W-1:0] count_q;

	assign full      = (count_q == Q_CNT_W'(Q_DEPTH));
	assign not_empty = (count_q != '0);
	assign head      = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_q + Q_PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_q + Q_PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + Q_CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - Q_CNT_W'(1);
			end
		end
	end

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && full) && !(pop && !not_empty))
		else $error("queue overrun or underrun");

endmodule
`default_nettype wire

// ===== rtl/bcpu_back.sv =====
// back end: turns jobs into echoed bytes, pad bytes and status items
`default_nettype none
module bcpu_back (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             job_valid,
	input  wire bcpu_pkg::job_t   job,
	output logic                  pop,
	output logic                  result_valid,
	input  wire logic             result_ready,
	output bcpu_pkg::out_item_t   result
);
	import bcpu_pkg::*;

	logic [BLK_W-1:0] idx_q;
	logic             valid_q;
	out_item_t        result_q;
	out_item_t        next_item;
	logic             load;
	logic             in_pads;

	assign load    = job_valid && (!valid_q || result_ready);
	assign in_pads = job.is_end && (idx_q != job.pads);
	assign pop     = load && !in_pads;

	always_comb begin
		next_item = '0;
		if (!job.is_end) begin
			next_item.out_byte = job.data_byte;
			next_item.out_kind = KIND_DATA;
		end else if (in_pads) begin
			next_item.out_byte = (idx_q == '0) ? job.first_byte : job.fill_byte;
			next_item.out_kind = KIND_PAD;
		end else begin
			next_item.out_kind     = KIND_STATUS;
			next_item.total_length = job.total;
			next_item.ok           = job.ok;
			next_item.last         = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			result_q <= next_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= '0;
		end else begin
			if (load) begin
				valid_q <= 1'b1;
			end else if (result_ready) begin
				valid_q <= 1'b0;
			end
			if (load) begin
				idx_q <= in_pads ? idx_q + BLK_W'(1) : '0;
			end
		end
	end

	assign result_valid = valid_q;
	assign result       = result_q;

	a_last_is_status: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q |-> (result_q.last == (result_q.out_kind == KIND_STATUS)))
		else $error("last flag disagrees with item kind");

endmodule
`default_nettype wire

// ===== rtl/block_cipher_pad_unpad_top.sv =====
// top level: configuration registers, front end, job queue and back end
// an item's result passes the job queue and then the output register
// one data byte per cycle unless the queue or output stalls; an end of message holds
// the back end for pad count plus one items, at most 33, one per cycle while result_ready
// is high; a shorter block length written mid message holds input while the position
// is reduced by one subtraction per cycle; reset clears all message state
`default_nettype none
module block_cipher_pad_unpad_top (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [bcpu_pkg::ADDR_W-1:0]   paddr,
	input  wire logic [bcpu_pkg::DATA_W-1:0]   pwdata,
	output logic [bcpu_pkg::DATA_W-1:0]        prdata,
	output logic                               pready,
	input  wire logic                          item_valid,
	output logic                               item_ready,
	input  wire bcpu_pkg::in_item_t            item,
	output logic                               result_valid,
	input  wire logic                          result_ready,
	output bcpu_pkg::out_item_t                result
);
	import bcpu_pkg::*;

	cfg_t       cfg_q;
	logic       wr_en;
	logic [1:0] reg_idx;
	logic       q_full;
	logic       q_not_empty;
	logic       q_push;
	logic       q_pop;
	job_t       q_push_job;
	job_t       q_head;

	assign pready  = 1'b1;
	assign reg_idx = paddr[3:2];
	assign wr_en   = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.scheme_mode  <= MODE_PKCS;
			cfg_q.direction    <= DIR_PAD;
			cfg_q.block_length <= BLOCK_RESET;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_SCHEME:    cfg_q.scheme_mode  <= pwdata[1:0];
				REG_DIRECTION: cfg_q.direction    <= pwdata[0];
				REG_BLOCK:     cfg_q.block_length <= pwdata[5:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_SCHEME:    prdata = DATA_W'(cfg_q.scheme_mode);
			REG_DIRECTION: prdata = DATA_W'(cfg_q.direction);
			REG_BLOCK:     prdata = DATA_W'(cfg_q.block_length);
			default:       prdata = '0;
		endcase
	end

	bcpu_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.in_valid (item_valid),
		.in_ready (item_ready),
		.in_item  (item),
		.full     (q_full),
		.push     (q_push),
		.push_job (q_push_job)
	);

	bcpu_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_job  (q_push_job),
		.full      (q_full),
		.not_empty (q_not_empty),
		.pop       (q_pop),
		.head      (q_head)
	);

	bcpu_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.job_valid    (q_not_empty),
		.job          (q_head),
		.pop          (q_pop),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

endmodule
`default_nettype wire

// ===== dv/testbench.sv =====
// self-checking testbench for the block cipher pad and unpad engine
`timescale 1ns / 1ps
module testbench;
	import bcpu_pkg::*;

	localparam int CYCLE_LIMIT  = 1000000;
	localparam int SETTLE_TICKS = 40;

	typedef logic [7:0] octet_q_t[$];

	logic                clk          = 1'b0;
	logic                arst_n       = 1'b0;
	logic                psel         = 1'b0;
	logic                penable      = 1'b0;
	logic                pwrite       = 1'b0;
	logic [ADDR_W-1:0]   paddr        = '0;
	logic [DATA_W-1:0]   pwdata       = '0;
	logic [DATA_W-1:0]   prdata;
	logic                pready;
	logic                item_valid   = 1'b0;
	logic                item_ready;
	in_item_t            item         = '0;
	logic                result_valid;
	logic                result_ready = 1'b0;
	out_item_t           result;

	// engine configuration and message state as the testbench sees them
	logic [1:0]  cfg_scheme = MODE_PKCS;
	logic        cfg_dir    = DIR_PAD;
	logic [5:0]  cfg_block  = BLOCK_RESET;
	int unsigned msg_count  = 0;
	int unsigned msg_pos    = 0;
	logic        len_sat    = 1'b0;
	int unsigned mark_idx   = 0;
	logic        mark_seen  = 1'b0;
	logic [7:0]  run_byte   = '0;
	int unsigned run_len    = 0;

	out_item_t   outputs_due[$];
	int          mismatches    = 0;
	int          send_idle_pct = 0;
	int          recv_idle_pct = 0;
	int unsigned cycle_count   = 0;

	block_cipher_pad_unpad_top dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	function automatic int unsigned block_in_use();
		if (cfg_block == 0)
			return 1;
		if (cfg_block > MAX_BLOCK)
			return MAX_BLOCK;
		return cfg_block;
	endfunction

	function automatic logic [5:0] pick_block();
		int unsigned r;
		r = $urandom_range(19);
		if (r == 0)
			return 6'd0;
		if (r == 1)
			return 6'd32;
		if (r == 2)
			return 6'($urandom_range(63, 33));
		return 6'($urandom_range(8, 1));
	endfunction

	function automatic logic [7:0] pick_octet();
		int unsigned r;
		r = $urandom_range(9);
		if (r == 0)
			return ZERO_BYTE;
		if (r == 1)
			return MARKER_BYTE;
		return 8'($urandom_range(255));
	endfunction

	// works out the outputs that one accepted item causes and queues them
	task automatic pad_engine_step(input in_item_t it);
		int unsigned blk, pos, pads, sum, v;
		logic [1:0]  mode;
		logic        flag;
		out_item_t   r;
		blk  = block_in_use();
		pos  = msg_pos % blk;
		mode = (cfg_scheme == MODE_SPARE) ? MODE_ZERO : cfg_scheme;
		r    = '0;
		if (it.cmd == CMD_DATA) begin
			r.out_byte = it.data_byte;
			r.out_kind = KIND_DATA;
			outputs_due.push_back(r);
			if (it.data_byte == MARKER_BYTE) begin
				mark_idx  = msg_count;
				mark_seen = 1'b1;
			end else if (it.data_byte != ZERO_BYTE) begin
				mark_seen = 1'b0;
			end
			if (run_len != 0 && it.data_byte == run_byte) begin
				if (run_len < RUN_MAX)
					run_len++;
			end else begin
				run_byte = it.data_byte;
				run_len  = 1;
			end
			if (msg_count >= LEN_MAX)
				len_sat = 1'b1;
			else
				msg_count++;
			msg_pos = (pos + 1) % blk;
		end else begin
			sum  = 0;
			flag = 1'b0;
			if (cfg_dir == DIR_PAD) begin
				flag = !len_sat;
				if (mode == MODE_ZERO)
					pads = (pos == 0) ? 0 : blk - pos;
				else
					pads = blk - pos;
				for (int i = 0; i < pads; i++) begin
					r = '0;
					r.out_kind = KIND_PAD;
					if (mode == MODE_MARKER)
						r.out_byte = (i == 0) ? MARKER_BYTE : ZERO_BYTE;
					else if (mode == MODE_PKCS)
						r.out_byte = 8'(pads);
					else
						r.out_byte = ZERO_BYTE;
					outputs_due.push_back(r);
				end
				sum = msg_count + pads;
				if (sum > LEN_MAX) begin
					sum  = LEN_MAX;
					flag = 1'b0;
				end
			end else if (!len_sat && pos == 0) begin
				if (mode == MODE_ZERO) begin
					flag = 1'b1;
					sum  = msg_count;
				end else if (mode == MODE_MARKER) begin
					if (msg_count != 0 && mark_seen && mark_idx + blk >= msg_count) begin
						flag = 1'b1;
						sum  = mark_idx;
					end
				end else begin
					v = run_byte;
					if (msg_count != 0 && v != 0 && v <= blk && run_len >= v &&
							msg_count >= v) begin
						flag = 1'b1;
						sum  = msg_count - v;
					end
				end
			end
			r = '0;
			r.out_kind     = KIND_STATUS;
			r.total_length = LEN_W'(sum);
			r.ok           = flag;
			r.last         = 1'b1;
			outputs_due.push_back(r);
			msg_count = 0;
			msg_pos   = 0;
			len_sat   = 1'b0;
			mark_idx  = 0;
			mark_seen = 1'b0;
			run_byte  = '0;
			run_len   = 0;
		end
	endtask

	task automatic report_mismatch(input string what);
		$display("mismatch at cycle %0d: %0s", cycle_count, what);
		mismatches++;
	endtask

	task automatic check_output(input out_item_t got);
		out_item_t want;
		if (outputs_due.size() == 0) begin
			report_mismatch($sformatf("transfer with nothing due: %h", got));
		end else begin
			want = outputs_due.pop_front();
			if (got.out_byte != want.out_byte)
				report_mismatch($sformatf("out_byte %h, want %h", got.out_byte, want.out_byte));
			if (got.out_kind != want.out_kind)
				report_mismatch($sformatf("out_kind %0d, want %0d", got.out_kind, want.out_kind));
			if (got.total_length != want.total_length)
				report_mismatch($sformatf("total_length %0d, want %0d",
					got.total_length, want.total_length));
			if (got.ok != want.ok)
				report_mismatch($sformatf("ok %b, want %b", got.ok, want.ok));
			if (got.last != want.last)
				report_mismatch($sformatf("last %b, want %b", got.last, want.last));
		end
	endtask

	always @(negedge clk)
		result_ready <= (recv_idle_pct == 0) || ($urandom_range(99) >= recv_idle_pct);

	always @(posedge clk) begin
		if (arst_n && result_valid && result_ready)
			check_output(result);
	end

	task automatic send_item(input in_item_t it);
		while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
			item_valid = 1'b0;
			@(negedge clk);
		end
		item_valid = 1'b1;
		item       = it;
		do @(posedge clk); while (!item_ready);
		pad_engine_step(it);
		@(negedge clk);
	endtask

	task automatic send_data(input logic [7:0] value);
		send_item(in_item_t'({CMD_DATA, value}));
	endtask

	task automatic send_end();
		send_item(in_item_t'({CMD_END, 8'($urandom_range(255))}));
	endtask

	task automatic send_message(input octet_q_t body);
		foreach (body[i])
			send_data(body[i]);
		send_end();
	endtask

	task automatic wait_drained();
		item_valid = 1'b0;
		while (outputs_due.size() != 0)
			@(negedge clk);
		repeat (SETTLE_TICKS) @(negedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [5:0] value);
		psel    = 1'b1;
		penable = 1'b0;
		pwrite  = 1'b1;
		paddr   = ADDR_W'({idx, 2'b00});
		pwdata  = DATA_W'(value);
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		case (idx)
			REG_SCHEME:    cfg_scheme = value[1:0];
			REG_DIRECTION: cfg_dir    = value[0];
			REG_BLOCK:     cfg_block  = value;
			default: ;
		endcase
		@(negedge clk);
		psel    = 1'b0;
		penable = 1'b0;
		pwrite  = 1'b0;
	endtask

	task automatic configure(input logic [1:0] scheme, input logic dir,
			input logic [5:0] blk);
		wait_drained();
		write_reg(REG_SCHEME, 6'(scheme));
		write_reg(REG_DIRECTION, 6'(dir));
		write_reg(REG_BLOCK, blk);
	endtask

	// reset settings: pkcs padding on a 16 byte block
	task automatic test_reset_defaults();
		send_data(8'h00);
		send_data(8'hff);
		send_end();
	endtask

	task automatic test_pad_schemes();
		configure(MODE_ZERO, DIR_PAD, 6'd4);
		send_data(MARKER_BYTE);
		send_end();
		send_end();
		configure(MODE_MARKER, DIR_PAD, 6'd4);
		send_end();
		configure(MODE_SPARE, DIR_PAD, 6'd1);
		send_data(8'h55);
		send_end();
	endtask

	task automatic test_unpad_checks();
		configure(MODE_PKCS, DIR_UNPAD, 6'd2);
		send_data(8'haa);
		send_data(8'h01);
		send_end();
		send_data(ZERO_BYTE);
		send_data(ZERO_BYTE);
		send_end();
		send_data(8'h01);
		send_end();
		send_end();
		configure(MODE_MARKER, DIR_UNPAD, 6'd2);
		send_data(MARKER_BYTE);
		send_data(ZERO_BYTE);
		send_end();
		send_end();
		configure(MODE_ZERO, DIR_UNPAD, 6'd2);
		send_end();
	endtask

	// out of range block lengths and a shorter block written mid message
	task automatic test_block_edges();
		configure(MODE_PKCS, DIR_PAD, 6'd63);
		for (int i = 0; i < 5; i++)
			send_data(8'(i + 1));
		wait_drained();
		write_reg(REG_BLOCK, 6'd3);
		send_end();
		configure(MODE_PKCS, DIR_PAD, 6'd0);
		send_data(8'h7f);
		send_end();
	endtask

	task automatic test_random_messages(input int budget);
		int          sent;
		int unsigned blk, len, v, cut;
		logic [1:0]  mode;
		octet_q_t    body;
		sent = 0;
		while (sent < budget) begin
			if ($urandom_range(99) < 8) begin
				send_item(in_item_t'({1'($urandom_range(3) == 0), 8'($urandom_range(255))}));
				sent++;
			end else begin
				if ($urandom_range(2) == 0)
					configure(2'($urandom_range(3)), 1'($urandom_range(1)), pick_block());
				blk  = block_in_use();
				mode = (cfg_scheme == MODE_SPARE) ? MODE_ZERO : cfg_scheme;
				len  = $urandom_range(blk + 2);
				body.delete();
				for (int i = 0; i < len; i++)
					body.push_back(pick_octet());
				if (cfg_dir == DIR_UNPAD) begin
					if (mode == MODE_MARKER)
						body.push_back(MARKER_BYTE);
					if (mode == MODE_PKCS) begin
						v = blk - (len % blk);
						repeat (v) body.push_back(8'(v));
					end else begin
						while (body.size() % blk != 0)
							body.push_back(ZERO_BYTE);
					end
					if ($urandom_range(4) == 0) begin
						case ($urandom_range(2))
							0: if (body.size() != 0)
								body[$urandom_range(body.size() - 1)] = 8'($urandom_range(255));
							1: if (body.size() != 0)
								void'(body.pop_back());
							default: body.push_back(pick_octet());
						endcase
					end
				end
				if ($urandom_range(9) == 0 && body.size() > 1) begin
					cut = body.size() / 2;
					for (int i = 0; i < cut; i++)
						send_data(body[i]);
					wait_drained();
					write_reg(REG_BLOCK, pick_block());
					for (int i = cut; i < body.size(); i++)
						send_data(body[i]);
					send_end();
				end else begin
					send_message(body);
				end
				sent += body.size() + 1;
			end
		end
	endtask

	initial begin
		repeat (2) @(negedge clk);
		arst_n = 1'b1;

		send_idle_pct = 35;
		recv_idle_pct = 64;
		test_reset_defaults();
		test_pad_schemes();
		test_unpad_checks();
		test_block_edges();

		test_random_messages(100);
		send_idle_pct = 64;
		recv_idle_pct = 35;
		test_random_messages(100);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_random_messages(100);

		wait_drained();
		if (mismatches == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
